/* sv/suv_pkg.sv */
// Package for the sphere UV mapping pipeline: item type, constants, CORDIC helpers.
`default_nettype none
package suv_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_USED   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int SQRT_STEPS    = 22;
    localparam int W             = 27;
    localparam int SQ_W          = 43;
    localparam int IDX_W         = 5;

    localparam logic signed [W-1:0] QUARTER_TURN = W'(4194304);
    localparam logic signed [W-1:0] HALF_TURN    = W'(8388608);
    localparam logic signed [W-1:0] FULL_TURN    = W'(16777216);
    localparam logic signed [17:0]  Y_POLE       = 18'sd8192;

    localparam logic [16:0] Q16_ONE  = 17'd65536;
    localparam logic [16:0] Q16_HALF = 17'd32768;

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_TOP    = 2'd1,
        KIND_BOTTOM = 2'd2,
        KIND_OFF    = 2'd3
    } suv_kind_t;

    typedef struct packed {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic signed [W-1:0] acc;
    } suv_vec_t;

    typedef struct packed {
        suv_kind_t        kind;
        logic             z_zero;
        logic             z_neg;
        logic             x_neg;
        suv_vec_t         u;
        suv_vec_t         v;
        logic [SQ_W-1:0]  sq_n;
        logic [SQ_W-1:0]  sq_res;
    } suv_item_t;

    function automatic logic signed [W-1:0] atan_turns(input logic [IDX_W-1:0] i);
        logic signed [W-1:0] r;
        unique case (i)
            5'd0:    r = W'(2097152);
            5'd1:    r = W'(1238021);
            5'd2:    r = W'(654136);
            5'd3:    r = W'(332050);
            5'd4:    r = W'(166669);
            5'd5:    r = W'(83416);
            5'd6:    r = W'(41718);
            5'd7:    r = W'(20860);
            5'd8:    r = W'(10430);
            5'd9:    r = W'(5215);
            5'd10:   r = W'(2608);
            5'd11:   r = W'(1304);
            5'd12:   r = W'(652);
            5'd13:   r = W'(326);
            5'd14:   r = W'(163);
            5'd15:   r = W'(81);
            5'd16:   r = W'(41);
            5'd17:   r = W'(20);
            5'd18:   r = W'(10);
            5'd19:   r = W'(5);
            5'd20:   r = W'(3);
            5'd21:   r = W'(1);
            5'd22:   r = W'(1);
            default: r = W'(0);
        endcase
        return r;
    endfunction

    // One vectoring rotation: drive b toward zero.
    function automatic suv_vec_t cordic_step(input suv_vec_t p, input logic [IDX_W-1:0] i);
        suv_vec_t            r;
        logic signed [W-1:0] da;
        logic signed [W-1:0] db;
        da = p.b >>> i;
        db = p.a >>> i;
        if (!p.b[W-1]) begin
            r.a   = p.a + da;
            r.b   = p.b - db;
            r.acc = p.acc + atan_turns(i);
        end else begin
            r.a   = p.a - da;
            r.b   = p.b + db;
            r.acc = p.acc - atan_turns(i);
        end
        return r;
    endfunction

    function automatic logic [16:0] to_q16(input logic signed [W-1:0] val);
        logic signed [W-1:0] t;
        logic signed [W-1:0] q;
        logic [16:0]         r;
        t = val[W-1] ? W'(0) : val;
        q = (t + W'(128)) >>> 8;
        if (q > W'(65536)) begin
            r = Q16_ONE;
        end else begin
            r = q[16:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/sphere_uv_mapping.sv */
// Top level of the sphere UV mapping pipeline: input stage, cell chain, output stage.
//
//  channel | signals                                  | direction | payload
//  --------+------------------------------------------+-----------+----------------------------
//  in      | in_valid / in_ready                      | to block  | point_x, point_y, point_z
//  out     | out_valid / out_ready                    | from block| coords_valid, tex_u, tex_v
//  cfg     | psel penable pwrite paddr pwdata prdata  | to block  | pole_tolerance at 0x0
//
//  One item enters per cycle while the output is not held; the chain is the input
//  stage, the 22 square-root cells followed by the 16 CORDIC cells, and the output stage.
//  Reset clears every valid bit and sets pole_tolerance to 2.
//  Each stage moves on when the stage after it is empty or moving, so bubbles
//  collapse and items keep entering while a result waits at the output.
`default_nettype none
module sphere_uv_mapping (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic signed [15:0] point_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    coords_valid,
    output logic [16:0]             tex_u,
    output logic [16:0]             tex_v,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import suv_pkg::*;

    localparam int NCELL = SQRT_STEPS + CORDIC_USED;

    // ---------------- configuration ----------------
    logic [9:0] tol_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {22'd0, tol_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tol_reg <= 10'd2;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            tol_reg <= pwdata[9:0];
        end
    end

    // ---------------- chain wiring ----------------
    logic      ch_valid [NCELL+1];
    suv_item_t ch_data  [NCELL+1];
    logic      ch_ready [NCELL+1];

    // ---------------- input stage ----------------
    logic      in_v_reg;
    suv_item_t in_d_reg;
    suv_item_t in_d_next;

    logic signed [17:0] dt;
    logic signed [17:0] db;
    logic [17:0]        dt_abs;
    logic [17:0]        db_abs;
    logic signed [31:0] yy;
    logic signed [W-1:0] xa;
    logic signed [W-1:0] zb;

    always_comb begin
        dt     = 18'(point_y) - Y_POLE;
        db     = 18'(point_y) + Y_POLE;
        dt_abs = dt[17] ? 18'(-dt) : 18'(dt);
        db_abs = db[17] ? 18'(-db) : 18'(db);
        yy     = point_y * point_y;
        xa     = {{(W-24){point_x[15]}}, point_x, 8'd0};
        zb     = {{(W-24){point_z[15]}}, point_z, 8'd0};

        in_d_next = '0;
        priority if (dt_abs < {8'd0, tol_reg}) begin
            in_d_next.kind = KIND_TOP;
        end else if (db_abs < {8'd0, tol_reg}) begin
            in_d_next.kind = KIND_BOTTOM;
        end else if (point_y > 16'sd8192 || point_y < -16'sd8192) begin
            in_d_next.kind = KIND_OFF;
        end else begin
            in_d_next.kind = KIND_NORMAL;
        end
        in_d_next.z_zero = (point_z == 16'sd0);
        in_d_next.z_neg  = point_z[15];
        in_d_next.x_neg  = point_x[15];

        // quarter-turn pre-rotation brings x into the right half plane
        if (xa[W-1]) begin
            if (!zb[W-1]) begin
                in_d_next.u.a   = zb;
                in_d_next.u.b   = -xa;
                in_d_next.u.acc = QUARTER_TURN;
            end else begin
                in_d_next.u.a   = -zb;
                in_d_next.u.b   = xa;
                in_d_next.u.acc = -QUARTER_TURN;
            end
        end else begin
            in_d_next.u.a   = xa;
            in_d_next.u.b   = zb;
            in_d_next.u.acc = '0;
        end

        in_d_next.v.a    = '0;
        in_d_next.v.b    = {{(W-24){point_y[15]}}, point_y, 8'd0};
        in_d_next.v.acc  = '0;
        in_d_next.sq_n   = (SQ_W'(1) << 42) - {yy[26:0], 16'd0};
        in_d_next.sq_res = '0;
    end

    assign in_ready = !in_v_reg || ch_ready[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_v_reg <= 1'b0;
        end else if (in_ready) begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            in_d_reg <= in_d_next;
        end
    end

    assign ch_valid[0] = in_v_reg;
    assign ch_data[0]  = in_d_reg;

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        if (g < SQRT_STEPS) begin : g_sqrt
            suv_sqrt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .stage      (IDX_W'(g)),
                .up_valid   (ch_valid[g]),
                .up_data    (ch_data[g]),
                .up_ready   (ch_ready[g]),
                .down_valid (ch_valid[g+1]),
                .down_data  (ch_data[g+1]),
                .down_ready (ch_ready[g+1])
            );
        end else begin : g_cordic
            suv_cordic_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .stage      (IDX_W'(g - SQRT_STEPS)),
                .up_valid   (ch_valid[g]),
                .up_data    (ch_data[g]),
                .up_ready   (ch_ready[g]),
                .down_valid (ch_valid[g+1]),
                .down_data  (ch_data[g+1]),
                .down_ready (ch_ready[g+1])
            );
        end
    end

    // ---------------- output stage ----------------
    suv_item_t           fin;
    logic signed [W-1:0] mag;
    logic signed [W-1:0] tv;
    logic [16:0]         u_next;
    logic [16:0]         v_next;
    logic                cv_next;

    logic        out_v_reg;
    logic        cv_reg;
    logic [16:0] u_reg;
    logic [16:0] v_reg;

    always_comb begin
        fin = ch_data[NCELL];
        mag = fin.u.acc[W-1] ? -fin.u.acc : fin.u.acc;
        if (mag > HALF_TURN) begin
            mag = HALF_TURN;
        end
        tv = fin.v.acc;
        if (tv > QUARTER_TURN) begin
            tv = QUARTER_TURN;
        end else if (tv < -QUARTER_TURN) begin
            tv = -QUARTER_TURN;
        end

        unique case (fin.kind)
            KIND_TOP: begin
                cv_next = 1'b1;
                u_next  = Q16_HALF;
                v_next  = Q16_ONE;
            end
            KIND_BOTTOM: begin
                cv_next = 1'b1;
                u_next  = Q16_HALF;
                v_next  = '0;
            end
            KIND_OFF: begin
                cv_next = 1'b0;
                u_next  = '0;
                v_next  = '0;
            end
            default: begin
                cv_next = 1'b1;
                if (fin.z_zero) begin
                    // azimuth undefined along the x axis: pick the seam
                    u_next = fin.x_neg ? Q16_HALF : Q16_ONE;
                end else if (fin.z_neg) begin
                    u_next = to_q16(mag);
                end else begin
                    u_next = to_q16(FULL_TURN - mag);
                end
                v_next = to_q16((tv <<< 1) + HALF_TURN);
            end
        endcase
    end

    assign ch_ready[NCELL] = !out_v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end else if (ch_ready[NCELL]) begin
            out_v_reg <= ch_valid[NCELL];
        end
    end

    always_ff @(posedge clk) begin
        if (ch_ready[NCELL] && ch_valid[NCELL]) begin
            cv_reg <= cv_next;
            u_reg  <= u_next;
            v_reg  <= v_next;
        end
    end

    assign out_valid    = out_v_reg;
    assign coords_valid = cv_reg;
    assign tex_u        = u_reg;
    assign tex_v        = v_reg;

    // ---------------- assertions ----------------
    // input can only stall when the whole chain is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while chain has room");

    // off-sphere items carry zero coordinates
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !coords_valid) |-> (tex_u == 17'd0 && tex_v == 17'd0))
        else $error("off-sphere item with nonzero coordinates");

    // coordinates never exceed one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tex_u <= Q16_ONE && tex_v <= Q16_ONE))
        else $error("texture coordinate above one");

endmodule
`default_nettype wire

/* sv/suv_sqrt_cell.sv */
// One step of the digit-by-digit square root, registered, with its valid bit.
`default_nettype none
module suv_sqrt_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [4:0]            stage,
    input  wire logic                  up_valid,
    input  wire suv_pkg::suv_item_t    up_data,
    output logic                       up_ready,
    output logic                       down_valid,
    output suv_pkg::suv_item_t         down_data,
    input  wire logic                  down_ready
);
    import suv_pkg::*;

    logic        valid_reg;
    suv_item_t   data_reg;
    suv_item_t   data_next;
    logic [SQ_W:0] trial;
    logic [SQ_W-1:0] bit_val;
    logic [5:0]  shamt;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb begin
        shamt   = 6'd42 - {stage, 1'b0};
        bit_val = SQ_W'(1) << shamt;
        trial   = {1'b0, up_data.sq_res} + {1'b0, bit_val};
        data_next = up_data;
        if ({1'b0, up_data.sq_n} >= trial) begin
            data_next.sq_n   = up_data.sq_n - trial[SQ_W-1:0];
            data_next.sq_res = (up_data.sq_res >> 1) + bit_val;
        end else begin
            data_next.sq_res = up_data.sq_res >> 1;
        end
        // hand the running root to the elevation CORDIC lane
        data_next.v.a = W'(data_next.sq_res);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

/* sv/suv_cordic_cell.sv */
// One CORDIC vectoring stage for both the azimuth and the elevation lane.
`default_nettype none
module suv_cordic_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [4:0]            stage,
    input  wire logic                  up_valid,
    input  wire suv_pkg::suv_item_t    up_data,
    output logic                       up_ready,
    output logic                       down_valid,
    output suv_pkg::suv_item_t         down_data,
    input  wire logic                  down_ready
);
    import suv_pkg::*;

    logic      valid_reg;
    suv_item_t data_reg;
    suv_item_t data_next;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb begin
        data_next   = up_data;
        data_next.u = cordic_step(up_data.u, stage);
        data_next.v = cordic_step(up_data.v, stage);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the sphere UV mapping block: directed and random points checked against a predictor.
`timescale 1ns / 1ps
module tb;

    // Wait length for draining the pipeline; drain() adds a margin on top.
    localparam int PIPE_LAT = 40;

    typedef struct packed {
        logic        ok;
        logic [16:0] u;
        logic [16:0] v;
    } texel_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               out_valid;
    logic               out_ready;
    logic               coords_valid;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor copy of the tolerance register.
    logic [9:0] tol_shadow;
    texel_t     texel_q[$];
    int         mismatches;
    bit         stall_on;

    sphere_uv_mapping dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .coords_valid(coords_valid), .tex_u(tex_u), .tex_v(tex_v),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Arctangent table in units of 2^-24 turn.
    function automatic longint atan_entry(input int i);
        longint tbl[24];
        tbl = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                10430, 5215, 2608, 1304, 652, 326, 163, 81,
                41, 20, 10, 5, 3, 1, 1, 0};
        return tbl[i];
    endfunction

    // Shift toward minus infinity.
    function automatic longint shr_floor(input longint val, input int sh);
        return (val >= 0) ? (val >> sh) : (-1 - ((-1 - val) >> sh));
    endfunction

    function automatic longint isqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 42;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC: angle of (a, b) in turns scaled by 2^24.
    function automatic longint azimuth(input longint a, input longint b);
        longint acc;
        longint t;
        longint da;
        longint db;
        acc = 0;
        if (a < 0) begin
            t = a;
            if (b >= 0) begin
                a = b; b = -t; acc = 4194304;
            end else begin
                a = -b; b = t; acc = -4194304;
            end
        end
        for (int i = 0; i < 16; i++) begin
            da = shr_floor(b, i);
            db = shr_floor(a, i);
            if (b >= 0) begin
                a += da; b -= db; acc += atan_entry(i);
            end else begin
                a -= da; b += db; acc -= atan_entry(i);
            end
        end
        return acc;
    endfunction

    function automatic logic [16:0] turn_to_q16(input longint val);
        longint q;
        if (val < 0) val = 0;
        q = (val + 128) >> 8;
        return (q > 65536) ? 17'd65536 : q[16:0];
    endfunction

    function automatic texel_t map_point(input logic signed [15:0] px,
                                         input logic signed [15:0] py,
                                         input logic signed [15:0] pz);
        texel_t r;
        longint x, y, z, dt, db, mag, s, c, t;
        x = px; y = py; z = pz;
        dt = y - 8192;
        db = y + 8192;
        if (dt < 0) dt = -dt;
        if (db < 0) db = -db;
        if (dt < longint'(tol_shadow)) begin
            r = '{1'b1, 17'd32768, 17'd65536};
        end else if (db < longint'(tol_shadow)) begin
            r = '{1'b1, 17'd32768, 17'd0};
        end else if (y > 8192 || y < -8192) begin
            r = '{1'b0, 17'd0, 17'd0};
        end else begin
            r.ok = 1'b1;
            if (z == 0) begin
                r.u = (x >= 0) ? 17'd65536 : 17'd32768;
            end else begin
                mag = azimuth(x * 256, z * 256);
                if (mag < 0) mag = -mag;
                if (mag > 8388608) mag = 8388608;
                r.u = (z < 0) ? turn_to_q16(mag) : turn_to_q16(16777216 - mag);
            end
            s = y * 256;
            c = isqrt((64'd1 << 42) - longint'(s * s));
            t = azimuth(c, s);
            if (t > 4194304) t = 4194304;
            if (t < -4194304) t = -4194304;
            r.v = turn_to_q16(2 * t + 8388608);
        end
        return r;
    endfunction

    // Send one item, after a random gap when stalls are on; hold valid and payload until accepted.
    task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] pz);
        int gap;
        gap = stall_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= px;
        point_y  <= py;
        point_z  <= pz;
        texel_q.insert(texel_q.size(), map_point(px, py, pz));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // Wait until every result is back, then let the pipe drain fully.
    task automatic drain();
        int guard;
        drop_valid();
        guard = 0;
        while (texel_q.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [9:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {22'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tol_shadow = val;
    endtask

    // Random y that favors the sphere's height and the pole neighborhoods.
    function automatic logic [15:0] rand_y();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 16'($signed($urandom_range(0, 16384)) - 8192);
        if (sel < 8) return 16'(($urandom_range(0, 1) ? 8192 : -8192)
                               + $signed($urandom_range(0, 2100)) - 1050);
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_xz();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'd0;
        if (sel < 7) return 16'($signed($urandom_range(0, 16384)) - 8192);
        return 16'($urandom);
    endfunction

    task automatic test_extremes();
        logic [15:0] ext[5];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        for (int i = 0; i < 5; i++)
            send_point(ext[i], ext[(i + 2) % 5], ext[(i + 4) % 5]);
        send_point(16'h8000, 16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h0000, 16'h8000);
    endtask

    task automatic test_poles_and_rim();
        // Top and bottom tips and their neighbours, inside or outside the tolerance as it is set.
        send_point(16'd100, 16'd8192, 16'd50);
        send_point(16'd100, 16'd8193, 16'd50);
        send_point(16'd100, 16'd8191, 16'd50);
        send_point(16'd100, -16'sd8192, 16'd50);
        send_point(16'd100, -16'sd8191, 16'd50);
        // Just past the tips: off the sphere unless within the tolerance.
        send_point(16'd100, 16'd8194, 16'd50);
        send_point(16'd100, -16'sd8194, 16'd50);
    endtask

    task automatic test_azimuth_sign();
        // z exactly zero on both sides of x and on the y axis, small z of each sign, and x zero with z of each sign.
        send_point(16'd4000, 16'd0, 16'd0);
        send_point(-16'sd4000, 16'd0, 16'd0);
        send_point(16'd0, 16'd1000, 16'd0);
        send_point(-16'sd4000, 16'd0, 16'd1);
        send_point(-16'sd4000, 16'd0, -16'sd1);
        send_point(16'd0, -16'sd3000, 16'd4000);
        send_point(16'd0, 16'd3000, -16'sd4000);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_point(rand_xz(), rand_y(), rand_xz());
    endtask

    // Compare each result against the oldest prediction.
    always @(posedge clk) begin
        texel_t exp_t;
        if (rst_n && out_valid && out_ready) begin
            if (texel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result u=%0d v=%0d", tex_u, tex_v);
            end else begin
                exp_t = texel_q.pop_front();
                if (coords_valid !== exp_t.ok || tex_u !== exp_t.u || tex_v !== exp_t.v) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ok=%0d u=%0d v=%0d got ok=%0d u=%0d v=%0d",
                                 exp_t.ok, exp_t.u, exp_t.v, coords_valid, tex_u, tex_v);
                end
            end
        end
    end

    // Stall the result side at random, item by item.
    always @(posedge clk) begin
        int hold;
        if (!rst_n) begin
            out_ready <= 1'b1;
        end else if (stall_on && out_valid && out_ready) begin
            hold = $urandom_range(0, 19);
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        point_x    = '0;
        point_y    = '0;
        point_z    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches = 0;
        stall_on   = 1'b0;
        tol_shadow = 10'd2;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset tolerance first, back to back.
        test_extremes();
        test_poles_and_rim();
        test_azimuth_sign();
        drain();

        write_tolerance(10'd0);
        stall_on = 1'b1;
        test_poles_and_rim();
        test_random(300);
        drain();

        write_tolerance(10'd1023);
        test_poles_and_rim();
        test_random(400);
        drain();

        write_tolerance(10'd37);
        test_random(400);
        // Hold off the sender until the pipe has emptied, then resume.
        drop_valid();
        while (texel_q.size() != 0) @(posedge clk);
        test_random(300);
        stall_on = 1'b0;
        test_random(200);
        drain();

        write_tolerance(10'd2);
        stall_on = 1'b1;
        test_random(300);
        drain();

        if (mismatches == 0 && texel_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
